FILE: sv/rrbo_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables of the rounded rectangle outline generator.
// Depends on nothing; the modules and the testbench of the block use it by scoped names.
package rrbo_pkg;

    // Sizes
    localparam int MAX_SEGMENTS = 15;
    localparam int SEG_W        = 4;
    localparam int PC_W         = 5;
    localparam int RAD_W        = 15;

    // Configuration register indexes and reset values
    localparam logic             CFG_RADIUS     = 1'b0;
    localparam logic             CFG_SEGMENTS   = 1'b1;
    localparam logic [RAD_W-1:0] RADIUS_RESET   = 15'd128;
    localparam logic [SEG_W-1:0] SEGMENTS_RESET = 4'd8;

    // (1 - kappa) in Q0.16
    localparam logic signed [17:0] ONE_MINUS_KAPPA = 18'sd29345;

    // Microcode addresses
    localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;
    localparam logic [PC_W-1:0] PC_VERTEX = 5'd3;

    // Sequencer operations
    localparam logic [1:0] SQ_WAIT_IN = 2'd0;
    localparam logic [1:0] SQ_NEXT    = 2'd1;
    localparam logic [1:0] SQ_EMIT    = 2'd2;

    // Multiplier operand A sources
    localparam logic [2:0] MA_U   = 3'd0;
    localparam logic [2:0] MA_UU  = 3'd1;
    localparam logic [2:0] MA_TT  = 3'd2;
    localparam logic [2:0] MA_W0  = 3'd3;
    localparam logic [2:0] MA_W1  = 3'd4;
    localparam logic [2:0] MA_W2  = 3'd5;
    localparam logic [2:0] MA_RAD = 3'd6;
    localparam logic [2:0] MA_T   = 3'd7;

    // Multiplier operand B sources
    localparam logic [2:0] MB_U     = 3'd0;
    localparam logic [2:0] MB_T     = 3'd1;
    localparam logic [2:0] MB_D0    = 3'd2;
    localparam logic [2:0] MB_D1    = 3'd3;
    localparam logic [2:0] MB_D2    = 3'd4;
    localparam logic [2:0] MB_KAPPA = 3'd5;

    // Product write-back targets
    localparam logic [2:0] WB_NONE = 3'd0;
    localparam logic [2:0] WB_UU   = 3'd1;
    localparam logic [2:0] WB_TT   = 3'd2;
    localparam logic [2:0] WB_W0   = 3'd3;
    localparam logic [2:0] WB_W1   = 3'd4;
    localparam logic [2:0] WB_W2   = 3'd5;
    localparam logic [2:0] WB_RK   = 3'd6;

    // Accumulator operations
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_BASE = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // Axis select
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // One microcode control word
    typedef struct packed {
        logic [1:0] seq;
        logic       tload;
        logic       mul_en;
        logic [2:0] mul_a;
        logic [2:0] mul_b;
        logic [2:0] wb;
        logic [1:0] acc_op;
        logic       axis;
        logic       vx_ld;
    } t_uword;

    // Sequencer status handed to the datapath
    typedef struct packed {
        logic             accept;
        logic             emit;
        logic [1:0]       corner;
        logic [SEG_W-1:0] step;
        logic [SEG_W-1:0] seg;
        logic [5:0]       vnum;
        logic             last;
    } t_seq_status;

    // Sample positions t = round(i / seg) in Q0.16, indexed [seg][i]
    typedef logic [0:MAX_SEGMENTS][0:MAX_SEGMENTS][15:0] t_tq_table;

    function automatic t_tq_table build_tq_table();
        t_tq_table   tab;
        int          s;
        int          j;
        int          b;
        logic [20:0] num;
        logic [20:0] rem;
        logic [20:0] q;
        for (s = 0; s <= MAX_SEGMENTS; s++) begin
            for (j = 0; j <= MAX_SEGMENTS; j++) begin
                if (s > 0 && j < s) begin
                    // restoring long division of j*2^16 + s/2 by s
                    num = 21'(j * 65536 + (s >> 1));
                    rem = '0;
                    q   = '0;
                    for (b = 20; b >= 0; b--) begin
                        rem = {rem[19:0], num[b]};
                        if (rem >= 21'(s)) begin
                            rem  = rem - 21'(s);
                            q[b] = 1'b1;
                        end
                    end
                    tab[s][j] = q[15:0];
                end else begin
                    tab[s][j] = 16'd0;
                end
            end
        end
        return tab;
    endfunction

    localparam t_tq_table TQ_TABLE = build_tq_table();

endpackage

FILE: sv/rrbo_in_if.sv
`timescale 1ns / 1ps
// Input channel of the outline generator: one box size per word.
// Depends on nothing.
interface rrbo_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] box_width;
    logic [15:0] box_height;

    modport source(output valid, output box_width, output box_height, input ready);
    modport sink(input valid, input box_width, input box_height, output ready);
endinterface

FILE: sv/rrbo_out_if.sv
`timescale 1ns / 1ps
// Output channel of the outline generator: one polygon vertex per word.
// Depends on nothing.
interface rrbo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [5:0]         vertex_number;
    logic               last_vertex;

    modport source(output valid, output vertex_x, output vertex_y,
                   output vertex_number, output last_vertex, input ready);
    modport sink(input valid, input vertex_x, input vertex_y,
                 input vertex_number, input last_vertex, output ready);
endinterface

FILE: sv/rrbo_ucode_rom.sv
`timescale 1ns / 1ps
// Microcode store: maps the program counter to one control word.
// Depends on rrbo_pkg.
module rrbo_ucode_rom (
    input  logic [rrbo_pkg::PC_W-1:0] i_pc,
    output rrbo_pkg::t_uword          o_uword
);

    rrbo_pkg::t_uword s_w;

    // Decode the program: prologue computes rk, then one pass per vertex
    always_comb begin
        s_w = '{seq: rrbo_pkg::SQ_NEXT, tload: 1'b0, mul_en: 1'b0,
                mul_a: rrbo_pkg::MA_U, mul_b: rrbo_pkg::MB_U,
                wb: rrbo_pkg::WB_NONE, acc_op: rrbo_pkg::ACC_HOLD,
                axis: rrbo_pkg::AXIS_X, vx_ld: 1'b0};
        unique case (i_pc)
            5'd0: begin
                s_w.seq = rrbo_pkg::SQ_WAIT_IN;
            end
            5'd1: begin
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_RAD;
                s_w.mul_b  = rrbo_pkg::MB_KAPPA;
            end
            5'd2: begin
                s_w.wb = rrbo_pkg::WB_RK;
            end
            5'd3: begin
                s_w.tload = 1'b1;
            end
            5'd4: begin
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_U;
                s_w.mul_b  = rrbo_pkg::MB_U;
            end
            5'd5: begin
                s_w.wb     = rrbo_pkg::WB_UU;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_T;
                s_w.mul_b  = rrbo_pkg::MB_T;
            end
            5'd6: begin
                s_w.wb     = rrbo_pkg::WB_TT;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_UU;
                s_w.mul_b  = rrbo_pkg::MB_U;
            end
            5'd7: begin
                s_w.wb     = rrbo_pkg::WB_W0;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_UU;
                s_w.mul_b  = rrbo_pkg::MB_T;
            end
            5'd8: begin
                s_w.wb     = rrbo_pkg::WB_W1;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_TT;
                s_w.mul_b  = rrbo_pkg::MB_U;
            end
            5'd9: begin
                s_w.wb     = rrbo_pkg::WB_W2;
                s_w.acc_op = rrbo_pkg::ACC_BASE;
                s_w.axis   = rrbo_pkg::AXIS_X;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_W0;
                s_w.mul_b  = rrbo_pkg::MB_D0;
            end
            5'd10: begin
                s_w.acc_op = rrbo_pkg::ACC_ADD;
                s_w.axis   = rrbo_pkg::AXIS_X;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_W1;
                s_w.mul_b  = rrbo_pkg::MB_D1;
            end
            5'd11: begin
                s_w.acc_op = rrbo_pkg::ACC_ADD;
                s_w.axis   = rrbo_pkg::AXIS_X;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_W2;
                s_w.mul_b  = rrbo_pkg::MB_D2;
            end
            5'd12: begin
                s_w.acc_op = rrbo_pkg::ACC_ADD;
            end
            5'd13: begin
                s_w.vx_ld  = 1'b1;
                s_w.acc_op = rrbo_pkg::ACC_BASE;
                s_w.axis   = rrbo_pkg::AXIS_Y;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_W0;
                s_w.mul_b  = rrbo_pkg::MB_D0;
            end
            5'd14: begin
                s_w.acc_op = rrbo_pkg::ACC_ADD;
                s_w.axis   = rrbo_pkg::AXIS_Y;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_W1;
                s_w.mul_b  = rrbo_pkg::MB_D1;
            end
            5'd15: begin
                s_w.acc_op = rrbo_pkg::ACC_ADD;
                s_w.axis   = rrbo_pkg::AXIS_Y;
                s_w.mul_en = 1'b1;
                s_w.mul_a  = rrbo_pkg::MA_W2;
                s_w.mul_b  = rrbo_pkg::MB_D2;
            end
            5'd16: begin
                s_w.acc_op = rrbo_pkg::ACC_ADD;
            end
            5'd17: begin
                s_w.seq = rrbo_pkg::SQ_EMIT;
            end
            default: begin
                s_w.seq = rrbo_pkg::SQ_WAIT_IN;
            end
        endcase
    end

    assign o_uword = s_w;

endmodule

FILE: sv/rrbo_sequencer.sv
`timescale 1ns / 1ps
// Step counter with conditional jumps, vertex/corner counters and output valid.
// Depends on rrbo_pkg; takes control words from rrbo_ucode_rom.
module rrbo_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrbo_pkg::t_uword               i_uword,
    input  logic [rrbo_pkg::SEG_W-1:0]     i_segments,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rrbo_pkg::PC_W-1:0]      o_pc,
    output rrbo_pkg::t_seq_status          o_status
);

    logic [rrbo_pkg::PC_W-1:0]  r_pc, n_pc;
    logic [rrbo_pkg::SEG_W-1:0] r_seg, n_seg;
    logic [rrbo_pkg::SEG_W-1:0] r_step, n_step;
    logic [1:0]                 r_corner, n_corner;
    logic [5:0]                 r_vnum, n_vnum;
    logic                       r_last, n_last;
    logic                       r_out_valid, n_out_valid;
    logic                       s_accept;
    logic                       s_emit;
    logic                       s_slot_free;
    logic                       s_seg_end;

    assign o_in_ready  = (i_uword.seq == rrbo_pkg::SQ_WAIT_IN);
    assign s_accept    = i_in_valid && o_in_ready;
    assign s_slot_free = !r_out_valid || i_out_ready;
    assign s_emit      = (i_uword.seq == rrbo_pkg::SQ_EMIT) && s_slot_free;
    assign s_seg_end   = (r_step == r_seg - 4'd1);

    // Advance the program counter, hold while waiting on a handshake
    always_comb begin
        n_pc = r_pc;
        unique case (i_uword.seq)
            rrbo_pkg::SQ_WAIT_IN: begin
                if (s_accept) begin
                    n_pc = r_pc + 5'd1;
                end
            end
            rrbo_pkg::SQ_NEXT: begin
                n_pc = r_pc + 5'd1;
            end
            rrbo_pkg::SQ_EMIT: begin
                if (s_emit) begin
                    n_pc = r_last ? rrbo_pkg::PC_IDLE : rrbo_pkg::PC_VERTEX;
                end
            end
            default: begin
                n_pc = rrbo_pkg::PC_IDLE;
            end
        endcase
    end

    // Step through samples and corners; the closing vertex reuses corner 0, sample 0
    always_comb begin
        n_seg    = r_seg;
        n_step   = r_step;
        n_corner = r_corner;
        n_vnum   = r_vnum;
        n_last   = r_last;
        if (s_accept) begin
            n_seg    = (i_segments == 4'd0) ? 4'd1 : i_segments;
            n_step   = 4'd0;
            n_corner = 2'd0;
            n_vnum   = 6'd0;
            n_last   = 1'b0;
        end else if (s_emit) begin
            n_vnum = r_vnum + 6'd1;
            if (s_seg_end) begin
                n_step   = 4'd0;
                n_corner = r_corner + 2'd1;
                if (r_corner == 2'd3) begin
                    n_last = 1'b1;
                end
            end else begin
                n_step = r_step + 4'd1;
            end
        end
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (s_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= rrbo_pkg::PC_IDLE;
            r_seg       <= 4'd1;
            r_step      <= 4'd0;
            r_corner    <= 2'd0;
            r_vnum      <= 6'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_seg       <= n_seg;
            r_step      <= n_step;
            r_corner    <= n_corner;
            r_vnum      <= n_vnum;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_pc        = r_pc;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status.accept = s_accept;
        o_status.emit   = s_emit;
        o_status.corner = r_corner;
        o_status.step   = r_step;
        o_status.seg    = r_seg;
        o_status.vnum   = r_vnum;
        o_status.last   = r_last;
    end

endmodule

FILE: sv/rrbo_datapath.sv
`timescale 1ns / 1ps
// Datapath: shared multiplier, Bezier weight registers, accumulator, output word.
// Depends on rrbo_pkg; driven by the control word and the sequencer status.
module rrbo_datapath (
    input  logic                           i_clk,
    input  rrbo_pkg::t_uword               i_uword,
    input  rrbo_pkg::t_seq_status          i_st,
    input  logic [rrbo_pkg::RAD_W-1:0]     i_radius,
    input  logic [15:0]                    i_box_width,
    input  logic [15:0]                    i_box_height,
    output logic signed [15:0]             o_vertex_x,
    output logic signed [15:0]             o_vertex_y,
    output logic [5:0]                     o_vertex_number,
    output logic                           o_last_vertex
);

    logic [15:0]                r_w;
    logic [15:0]                r_h;
    logic [rrbo_pkg::RAD_W-1:0] r_rk;
    logic [15:0]                r_t;
    logic [16:0]                r_u;
    logic [32:0]                r_uu;
    logic [31:0]                r_tt;
    logic [32:0]                r_w0;
    logic [32:0]                r_w1;
    logic [32:0]                r_w2;
    logic signed [51:0]         r_prod;
    logic signed [51:0]         r_acc;
    logic signed [15:0]         r_vx;
    logic signed [15:0]         r_ox;
    logic signed [15:0]         r_oy;
    logic [5:0]                 r_onum;
    logic                       r_olast;

    logic [15:0]                s_tq;
    logic signed [33:0]         s_ma;
    logic signed [17:0]         s_mb;
    logic signed [51:0]         s_mprod;
    logic                       s_type_a;
    logic                       s_dneg;
    logic                       s_bneg;
    logic [16:0]                s_mag;
    logic signed [17:0]         s_diff;
    logic [51:0]                s_pu;
    logic [51:0]                s_p3;
    logic [51:0]                s_wsrc;
    logic [51:0]                s_rnd_full;
    logic [32:0]                s_rnd;
    logic [15:0]                s_full;
    logic [46:0]                s_term_f;
    logic [46:0]                s_term_r;
    logic signed [51:0]         s_base;
    logic [51:0]                s_rofs;
    logic signed [51:0]         s_rsum;
    logic signed [19:0]         s_q;
    logic signed [15:0]         s_sat;

    // Sample position of the current step
    assign s_tq = rrbo_pkg::TQ_TABLE[i_st.seg][i_st.step];

    // Corner geometry: two arc shapes, each mirrored by a sign
    assign s_type_a = ~(i_st.corner[0] ^ i_uword.axis);
    assign s_dneg   = s_type_a ? ~i_st.corner[1] : (i_st.corner[0] ^ i_st.corner[1]);
    assign s_bneg   = s_type_a ? ~i_st.corner[1] : ~(i_st.corner[0] ^ i_st.corner[1]);

    // Control point offset relative to the arc end point
    always_comb begin
        s_mag = 17'd0;
        case (i_uword.mul_b)
            rrbo_pkg::MB_D0: s_mag = {2'b0, i_radius};
            rrbo_pkg::MB_D1: s_mag = s_type_a ? {2'b0, i_radius} : {2'b0, r_rk};
            rrbo_pkg::MB_D2: s_mag = s_type_a ? ({2'b0, i_radius} - {2'b0, r_rk}) : 17'd0;
            default:         s_mag = 17'd0;
        endcase
    end

    assign s_diff = s_dneg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

    // Operand select
    always_comb begin
        s_ma = 34'sd0;
        case (i_uword.mul_a)
            rrbo_pkg::MA_U:   s_ma = $signed({17'd0, r_u});
            rrbo_pkg::MA_UU:  s_ma = $signed({1'b0, r_uu});
            rrbo_pkg::MA_TT:  s_ma = $signed({2'b0, r_tt});
            rrbo_pkg::MA_W0:  s_ma = $signed({1'b0, r_w0});
            rrbo_pkg::MA_W1:  s_ma = $signed({1'b0, r_w1});
            rrbo_pkg::MA_W2:  s_ma = $signed({1'b0, r_w2});
            rrbo_pkg::MA_RAD: s_ma = $signed({19'd0, i_radius});
            rrbo_pkg::MA_T:   s_ma = $signed({18'd0, r_t});
            default:          s_ma = 34'sd0;
        endcase
    end

    always_comb begin
        s_mb = 18'sd0;
        case (i_uword.mul_b)
            rrbo_pkg::MB_U:     s_mb = $signed({1'b0, r_u});
            rrbo_pkg::MB_T:     s_mb = $signed({2'b0, r_t});
            rrbo_pkg::MB_D0,
            rrbo_pkg::MB_D1,
            rrbo_pkg::MB_D2:    s_mb = s_diff;
            rrbo_pkg::MB_KAPPA: s_mb = rrbo_pkg::ONE_MINUS_KAPPA;
            default:            s_mb = 18'sd0;
        endcase
    end

    assign s_mprod = s_ma * s_mb;

    // Write-back: round Q0.48 products to Q0.32, optionally times three
    assign s_pu       = $unsigned(r_prod);
    assign s_p3       = s_pu + {s_pu[50:0], 1'b0};
    assign s_wsrc     = (i_uword.wb == rrbo_pkg::WB_W1 || i_uword.wb == rrbo_pkg::WB_W2) ?
                        s_p3 : s_pu;
    assign s_rnd_full = s_wsrc + 52'd32768;
    assign s_rnd      = s_rnd_full[48:16];

    // Centering base: end point times 2^32 minus half the box size times 2^32
    assign s_full   = (i_uword.axis == rrbo_pkg::AXIS_Y) ? r_h : r_w;
    assign s_term_f = {s_full, 31'd0};
    assign s_term_r = s_type_a ? {i_radius, 32'd0} : 47'd0;
    assign s_base   = s_bneg ? ($signed({5'd0, s_term_r}) - $signed({5'd0, s_term_f}))
                             : ($signed({5'd0, s_term_f}) - $signed({5'd0, s_term_r}));

    // Shift right by 32 rounding halves away from zero, then saturate
    assign s_rofs = r_acc[51] ? 52'h0_0000_7FFF_FFFF : 52'h0_0000_8000_0000;
    assign s_rsum = r_acc + $signed(s_rofs);
    assign s_q    = s_rsum[51:32];

    always_comb begin
        if (s_q > 20'sd32767) begin
            s_sat = 16'sh7FFF;
        end else if (s_q < -20'sd32768) begin
            s_sat = -16'sh8000;
        end else begin
            s_sat = s_q[15:0];
        end
    end

    // Latch the box on acceptance
    always_ff @(posedge i_clk) begin
        if (i_st.accept) begin
            r_w <= i_box_width;
            r_h <= i_box_height;
        end
    end

    // Load sample position and its complement
    always_ff @(posedge i_clk) begin
        if (i_uword.tload) begin
            r_t <= s_tq;
            r_u <= 17'h10000 - {1'b0, s_tq};
        end
    end

    // Register every product before it is used again
    always_ff @(posedge i_clk) begin
        if (i_uword.mul_en) begin
            r_prod <= s_mprod;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uword.wb)
            rrbo_pkg::WB_UU: r_uu <= s_pu[32:0];
            rrbo_pkg::WB_TT: r_tt <= s_pu[31:0];
            rrbo_pkg::WB_W0: r_w0 <= s_rnd;
            rrbo_pkg::WB_W1: r_w1 <= s_rnd;
            rrbo_pkg::WB_W2: r_w2 <= s_rnd;
            rrbo_pkg::WB_RK: r_rk <= s_rnd[rrbo_pkg::RAD_W-1:0];
            default: begin
            end
        endcase
    end

    // Accumulate the weighted offsets on top of the base
    always_ff @(posedge i_clk) begin
        case (i_uword.acc_op)
            rrbo_pkg::ACC_BASE: r_acc <= s_base;
            rrbo_pkg::ACC_ADD:  r_acc <= r_acc + r_prod;
            default: begin
            end
        endcase
    end

    // Hold x until y is done, then load the output word
    always_ff @(posedge i_clk) begin
        if (i_uword.vx_ld) begin
            r_vx <= s_sat;
        end
        if (i_st.emit) begin
            r_ox    <= r_vx;
            r_oy    <= s_sat;
            r_onum  <= i_st.vnum;
            r_olast <= i_st.last;
        end
    end

    assign o_vertex_x      = r_ox;
    assign o_vertex_y      = r_oy;
    assign o_vertex_number = r_onum;
    assign o_last_vertex   = r_olast;

endmodule

FILE: sv/rounded_rect_bezier_outline.sv
`timescale 1ns / 1ps
// Rounded rectangle outline generator: top level with configuration registers.
// Depends on rrbo_pkg, rrbo_in_if, rrbo_out_if and the three submodules.
//
// Usage:
//   i_box takes one word (box_width, box_height, unsigned 12.4). For it the block
//   sends 4*segments+1 words on o_vtx: centered, saturated vertex x/y in signed
//   12.4, the vertex number and last_vertex set on the closing vertex.
//   Registers: index 0 corner radius (11.4), index 1 segments per corner
//   (0 counts as 1); write them through i_cfg_we/i_cfg_index/i_cfg_data.
//   Operation: a microcode program with one shared 34x18 multiplier computes
//   each vertex with 11 multiplies; a prologue computes rk once per item, and
//   the first vertex is offered once the prologue and the first vertex pass
//   are done. i_box.ready is high only between outlines.
//   An output register holds each vertex; when the receiver stalls, the program
//   waits at its emit step and resumes when the word is taken.
//   Reset (synchronous, active low) sets radius 128, segments 8, empties the
//   output register and returns the program to its idle step.
module rounded_rect_bezier_outline (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rrbo_in_if.sink                           i_box,
    rrbo_out_if.source                        o_vtx,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [rrbo_pkg::RAD_W-1:0]        i_cfg_data
);

    logic [rrbo_pkg::RAD_W-1:0] r_radius;
    logic [rrbo_pkg::SEG_W-1:0] r_segments;
    logic [rrbo_pkg::PC_W-1:0]  s_pc;
    rrbo_pkg::t_uword           s_uword;
    rrbo_pkg::t_seq_status      s_status;
    logic                       s_in_ready;
    logic                       s_out_valid;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= rrbo_pkg::RADIUS_RESET;
            r_segments <= rrbo_pkg::SEGMENTS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rrbo_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data;
                rrbo_pkg::CFG_SEGMENTS: r_segments <= i_cfg_data[rrbo_pkg::SEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rrbo_ucode_rom u_rom (
        .i_pc    (s_pc),
        .o_uword (s_uword)
    );

    rrbo_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (s_uword),
        .i_segments  (r_segments),
        .i_in_valid  (i_box.valid),
        .o_in_ready  (s_in_ready),
        .i_out_ready (o_vtx.ready),
        .o_out_valid (s_out_valid),
        .o_pc        (s_pc),
        .o_status    (s_status)
    );

    rrbo_datapath u_dp (
        .i_clk           (i_clk),
        .i_uword         (s_uword),
        .i_st            (s_status),
        .i_radius        (r_radius),
        .i_box_width     (i_box.box_width),
        .i_box_height    (i_box.box_height),
        .o_vertex_x      (o_vtx.vertex_x),
        .o_vertex_y      (o_vtx.vertex_y),
        .o_vertex_number (o_vtx.vertex_number),
        .o_last_vertex   (o_vtx.last_vertex)
    );

    assign i_box.ready = s_in_ready;
    assign o_vtx.valid = s_out_valid;

endmodule

FILE: tb/tb_rounded_rect_bezier_outline.sv
`timescale 1ns / 1ps
// Testbench of the rounded rectangle outline generator: random box sizes and settings,
// each outline vertex checked against a fixed-point Bezier predictor.
// Depends on rrbo_pkg, rrbo_in_if, rrbo_out_if and rounded_rect_bezier_outline.
module tb_rounded_rect_bezier_outline;

    localparam int      RANDOM_BOXES      = 500;
    localparam int      LONG_HOLD_CYCLES  = 400;
    localparam int      SETTLE_CYCLES     = 24;
    localparam int      END_SETTLE_CYCLES = 40;
    localparam int      WATCHDOG_LIMIT    = 3000;
    localparam longint  KAPPA_COMPLEMENT  = 29345;  // (1 - kappa) in Q0.16

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [5:0]         num;
        logic               last;
    } outline_vertex_t;

    // Predicts the outline of each accepted box and checks vertices in order
    class outline_scoreboard;
        logic [rrbo_pkg::RAD_W-1:0] radius;
        logic [rrbo_pkg::SEG_W-1:0] segments;
        outline_vertex_t            pending_vertices[$];
        int                         errors;
        int                         boxes;
        int                         vertices;

        function new();
            radius   = rrbo_pkg::RADIUS_RESET;
            segments = rrbo_pkg::SEGMENTS_RESET;
            errors   = 0;
            boxes    = 0;
            vertices = 0;
        endfunction

        function void set_register(logic idx, logic [rrbo_pkg::RAD_W-1:0] data);
            if (idx == rrbo_pkg::CFG_RADIUS) begin
                radius = data;
            end else begin
                segments = data[rrbo_pkg::SEG_W-1:0];
            end
        endfunction

        // One centered coordinate of a cubic arc at t (Q0.16), rounded and saturated
        function logic [15:0] bezier_axis(longint t, longint p0, longint p1, longint p2,
                                          longint p3, longint full);
            longint u;
            longint w0;
            longint w1;
            longint w2;
            longint w3;
            longint acc;
            longint rounded;
            u  = 65536 - t;
            w0 = (u * u * u + 32768) >>> 16;
            w1 = (3 * u * u * t + 32768) >>> 16;
            w2 = (3 * u * t * t + 32768) >>> 16;
            w3 = (64'sd1 <<< 32) - w0 - w1 - w2;
            acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3 - full * (64'sd1 <<< 31);
            // round halves away from zero
            if (acc >= 0) begin
                rounded = (acc + (64'sd1 <<< 31)) >>> 32;
            end else begin
                rounded = -((-acc + (64'sd1 <<< 31)) >>> 32);
            end
            if (rounded > 32767) begin
                rounded = 32767;
            end
            if (rounded < -32768) begin
                rounded = -32768;
            end
            return rounded[15:0];
        endfunction

        // Build the expected polygon for one box
        function void note_box(logic [15:0] box_w, logic [15:0] box_h);
            longint          w;
            longint          h;
            longint          r;
            longint          rk;
            longint          t;
            longint          cx[4][4];
            longint          cy[4][4];
            int              seg;
            int              c;
            int              i;
            int              k;
            outline_vertex_t v;
            seg = segments;
            if (seg < 1) begin
                seg = 1;
            end
            if (seg > rrbo_pkg::MAX_SEGMENTS) begin
                seg = rrbo_pkg::MAX_SEGMENTS;
            end
            w  = longint'(box_w);
            h  = longint'(box_h);
            r  = longint'(radius);
            rk = (r * KAPPA_COMPLEMENT + 32768) >>> 16;
            // control points, corners taken (0,0), (W,0), (W,H), (0,H)
            cx[0] = '{0, 0, rk, r};             cy[0] = '{r, rk, 0, 0};
            cx[1] = '{w - r, w - rk, w, w};     cy[1] = '{0, 0, rk, r};
            cx[2] = '{w, w, w - rk, w - r};     cy[2] = '{h - r, h - rk, h, h};
            cx[3] = '{r, rk, 0, 0};             cy[3] = '{h, h, h - rk, h - r};
            k = 0;
            for (c = 0; c < 4; c++) begin
                for (i = 0; i < seg; i++) begin
                    t      = (longint'(i) * 65536 + seg / 2) / seg;
                    v.x    = bezier_axis(t, cx[c][0], cx[c][1], cx[c][2], cx[c][3], w);
                    v.y    = bezier_axis(t, cy[c][0], cy[c][1], cy[c][2], cy[c][3], h);
                    v.num  = k[5:0];
                    v.last = 1'b0;
                    pending_vertices.push_back(v);
                    k++;
                end
            end
            // closing vertex repeats the first point
            v.x    = bezier_axis(0, cx[0][0], cx[0][1], cx[0][2], cx[0][3], w);
            v.y    = bezier_axis(0, cy[0][0], cy[0][1], cy[0][2], cy[0][3], h);
            v.num  = k[5:0];
            v.last = 1'b1;
            pending_vertices.push_back(v);
            boxes++;
        endfunction

        function void check_vertex(outline_vertex_t got);
            outline_vertex_t want;
            vertices++;
            if (pending_vertices.size() == 0) begin
                $display("%0t: unexpected vertex x=%0d y=%0d num=%0d last=%0d", $time,
                         got.x, got.y, got.num, got.last);
                errors++;
                return;
            end
            want = pending_vertices.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: vertex %0d x expected %0d got %0d", $time, want.num,
                         want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: vertex %0d y expected %0d got %0d", $time, want.num,
                         want.y, got.y);
                errors++;
            end
            if (got.num !== want.num) begin
                $display("%0t: vertex number expected %0d got %0d", $time, want.num,
                         got.num);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: vertex %0d last expected %0d got %0d", $time, want.num,
                         want.last, got.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_vertices.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [rrbo_pkg::RAD_W-1:0] cfg_data;
    logic                       no_idle;
    logic                       long_hold_due;
    int                         idle_cycles;
    int                         settings_used;
    outline_scoreboard          sb;

    rrbo_in_if  box_if();
    rrbo_out_if vtx_if();

    rounded_rect_bezier_outline dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_box       (box_if),
        .o_vtx       (vtx_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one box word after a random gap and hold it until taken
    task automatic offer_box(logic [15:0] w, logic [15:0] h);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge clk);
            box_if.valid = 1'b0;
        end
        @(negedge clk);
        box_if.valid      = 1'b1;
        box_if.box_width  = w;
        box_if.box_height = h;
        do @(posedge clk); while (box_if.ready !== 1'b1);
        sb.note_box(w, h);
    endtask

    // Drop valid and wait until every predicted vertex has come back
    task automatic finish_outlines();
        @(negedge clk);
        box_if.valid = 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [rrbo_pkg::RAD_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_register(idx, data);
    endtask

    function automatic logic [15:0] random_dimension();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1:       return 16'($urandom_range(0, 2047));
            4:       return 16'($urandom_range(256, 8191));
            5:       return 16'($urandom_range(60000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [rrbo_pkg::RAD_W-1:0] random_radius();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 15'h7FFF;
            2:       return 15'($urandom_range(1, 255));
            3:       return 15'($urandom_range(0, 4095));
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    // Take output words after random stalls, with one long hold-off on request
    initial begin
        int gap;
        outline_vertex_t got;
        vtx_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                repeat (LONG_HOLD_CYCLES) begin
                    @(negedge clk);
                    vtx_if.ready = 1'b0;
                end
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            repeat (gap) begin
                @(negedge clk);
                vtx_if.ready = 1'b0;
            end
            @(negedge clk);
            vtx_if.ready = 1'b1;
            do @(posedge clk); while (vtx_if.valid !== 1'b1);
            got.x    = vtx_if.vertex_x;
            got.y    = vtx_if.vertex_y;
            got.num  = vtx_if.vertex_number;
            got.last = vtx_if.last_vertex;
            sb.check_vertex(got);
        end
    end

    // End the run when no word moves on either side for too long
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((box_if.valid === 1'b1 && box_if.ready === 1'b1) ||
                (vtx_if.valid === 1'b1 && vtx_if.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                    $display("tb_rounded_rect_bezier_outline: errors");
                    $finish;
                end
            end
        end
    end

    initial begin
        int random_boxes;
        int phase;
        int count;
        int n;
        sb                = new();
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = rrbo_pkg::CFG_RADIUS;
        cfg_data          = '0;
        box_if.valid      = 1'b0;
        box_if.box_width  = '0;
        box_if.box_height = '0;
        no_idle           = 1'b0;
        long_hold_due     = 1'b0;
        idle_cycles       = 0;
        settings_used     = 1;
        random_boxes      = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: empty and full boxes, mixed extremes
        offer_box(16'h0000, 16'h0000);
        offer_box(16'hFFFF, 16'hFFFF);
        offer_box(16'hFFFF, 16'h0000);
        offer_box(16'h0000, 16'hFFFF);
        offer_box(16'd5120, 16'd2560);
        finish_outlines();

        // Zero radius, zero segments (counts as one); upper data bits ignored
        write_register(rrbo_pkg::CFG_RADIUS, 15'h0000);
        write_register(rrbo_pkg::CFG_SEGMENTS, 15'h7FF0);
        offer_box(16'h0000, 16'h0000);
        offer_box(16'hFFFF, 16'hFFFF);
        offer_box(16'd1600, 16'd800);
        finish_outlines();

        // Largest radius, most segments: radius beyond the box, saturation
        write_register(rrbo_pkg::CFG_RADIUS, 15'h7FFF);
        write_register(rrbo_pkg::CFG_SEGMENTS, 15'h000F);
        offer_box(16'h0000, 16'h0000);
        offer_box(16'hFFFF, 16'hFFFF);
        offer_box(16'd1000, 16'd500);
        offer_box(16'h8000, 16'h0001);
        finish_outlines();

        // Tiny radius, two segments, alternating bit patterns
        write_register(rrbo_pkg::CFG_RADIUS, 15'h0001);
        write_register(rrbo_pkg::CFG_SEGMENTS, 15'h0002);
        offer_box(16'h0001, 16'h0001);
        offer_box(16'h5555, 16'hAAAA);
        offer_box(16'hAAAA, 16'h5555);
        finish_outlines();
        settings_used += 3;

        // Random phases: new settings, a burst of boxes, then drain
        phase = 0;
        while (random_boxes < RANDOM_BOXES) begin
            phase++;
            write_register(rrbo_pkg::CFG_RADIUS, random_radius());
            write_register(rrbo_pkg::CFG_SEGMENTS,
                           {11'($urandom), 4'($urandom_range(0, 15))});
            settings_used++;
            no_idle = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(20, 60);
            for (n = 0; n < count; n++) begin
                // stall the receiver while boxes keep coming
                if (phase == 2 && n == 5) begin
                    long_hold_due = 1'b1;
                end
                offer_box(random_dimension(), random_dimension());
                random_boxes++;
            end
            finish_outlines();
            no_idle = 1'b0;
        end

        repeat (END_SETTLE_CYCLES) @(posedge clk);
        $display("checked %0d vertices from %0d boxes over %0d radius/segment settings",
                 sb.vertices, sb.boxes, settings_used);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb_rounded_rect_bezier_outline: clean");
        end else begin
            $display("%0d mismatches, %0d vertices never arrived", sb.errors,
                     sb.outstanding());
            $display("tb_rounded_rect_bezier_outline: errors");
        end
        $finish;
    end

endmodule
